[src/stt_pkg.sv]
// Shared types, token codes and character tables for the text tokenizer.
// No dependencies; used by stt_front, stt_queue, stt_back and the top level.
package stt_pkg;

  localparam int KIND_W  = 6;
  localparam int ERR_W   = 3;
  localparam int FIELD_W = 24;
  localparam int COL_W   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_NUMBER, M_NUMDOT, M_FLOAT, M_STRING, M_OP, M_ENDED
  } mode_t;

  localparam logic [KIND_W-1:0] K_DOT     = 6'd7;
  localparam logic [KIND_W-1:0] K_KW0     = 6'd27;
  localparam logic [KIND_W-1:0] K_IDENT   = 6'd43;
  localparam logic [KIND_W-1:0] K_INT     = 6'd44;
  localparam logic [KIND_W-1:0] K_FLOAT   = 6'd45;
  localparam logic [KIND_W-1:0] K_STRING  = 6'd46;
  localparam logic [KIND_W-1:0] K_NEWLINE = 6'd47;
  localparam logic [KIND_W-1:0] K_ERROR   = 6'd48;
  localparam logic [KIND_W-1:0] K_END     = 6'd49;

  localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
  localparam logic [ERR_W-1:0] ERR_AMP    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAR    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_STRING = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BYTE   = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam logic [7:0] PUNCT_CH [9] = '{"(", ")", "{", "}", "[", "]", ",", ".", ";"};
  localparam logic [7:0] OP_FIRST [10] = '{"+", "-", "*", "/", "!", "=", "<", ">", "&", "|"};
  localparam logic [7:0] OP_SECOND [10] = '{"=", "=", "=", "=", "=", "=", "=", "=", "&", "|"};
  localparam logic [KIND_W-1:0] OP_SINGLE [10] =
    '{6'd9, 6'd11, 6'd13, 6'd15, 6'd17, 6'd19, 6'd21, 6'd23, K_ERROR, K_ERROR};
  localparam logic [KIND_W-1:0] OP_DOUBLE [10] =
    '{6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd25, 6'd26};
  localparam logic [ERR_W-1:0] OP_ERR [10] =
    '{ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE, ERR_NONE,
      ERR_AMP, ERR_BAR};

  // keyword text is right-justified: last character in the low byte
  localparam logic [63:0] KW_TEXT [16] = '{
    64'("break"), 64'("class"), 64'("continue"), 64'("do"), 64'("else"), 64'("false"),
    64'("for"), 64'("fun"), 64'("if"), 64'("in"), 64'("null"), 64'("return"),
    64'("self"), 64'("true"), 64'("var"), 64'("while")};
  localparam logic [3:0] KW_LEN [16] =
    '{4'd5, 4'd5, 4'd8, 4'd2, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd2, 4'd4, 4'd6, 4'd4,
      4'd4, 4'd3, 4'd5};

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ERR_W-1:0]   err;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] line;
    logic [COL_W-1:0]   col;
  } tok_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic push;
    logic full;
  } qwr_t;

  function automatic logic [15:0] kw_hits(input logic [2:0] idx, input logic [7:0] b);
    logic [15:0] h;
    int sh;
    h = '0;
    for (int k = 0; k < 16; k++) begin
      sh = 8 * (int'(KW_LEN[k]) - 1 - int'(idx));
      if ({1'b0, idx} < KW_LEN[k]) begin
        h[k] = (KW_TEXT[k][sh +: 8] == b);
      end
    end
    return h;
  endfunction

endpackage

[src/stt_queue.sv]
// Short bundle queue between the scanner front and the token back end.
// Depends on stt_pkg for bundle_t and the queue depth.
module stt_queue import stt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    avail,
  output bundle_t pop_data
);

  bundle_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic do_push, do_pop;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("bundle pushed into full queue");
`endif

endmodule

[src/stt_back.sv]
// Token back end: unpacks queued bundles into one token word per
// out_ready cycle. Depends on stt_pkg for bundle_t and tok_t.
module stt_back import stt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_avail,
  input  bundle_t q_data,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output tok_t    out_tok,
  output logic    out_last
);

  bundle_t    cur;
  logic       have;
  logic [1:0] idx;
  logic       fire;

  assign out_valid = have;
  assign out_tok   = cur.tok[idx];
  assign out_last  = (idx == cur.cnt - 2'd1);
  assign fire      = have && out_ready;
  assign q_pop     = !have || (fire && out_last);

  always_ff @(posedge clk) begin
    if (q_pop && q_avail) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      have <= q_avail;
      idx  <= '0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

[src/stt_front.sv]
// Scanner front: one byte per cycle while the queue is not full; updates
// lexer state, forms the token bundle that byte closes. Uses stt_pkg.
module stt_front import stt_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  qwr_t       qs,
  output logic       push,
  output bundle_t    bundle
);

  localparam int OW = OFFSET_BITS;
  localparam int CW = COLUMN_BITS;

  mode_t          mode, mode_next;
  logic [OW-1:0]  pos, pos_next, tstart, tstart_next, line, line_next, llen, llen_next;
  logic [OW-1:0]  dot_off, dot_off_next;
  logic [CW-1:0]  col, col_next, tcol, tcol_next, dot_col, dot_col_next;
  logic [15:0]    kw, kw_next;
  logic           esc, esc_next, held_dot, held_dot_next;
  logic [3:0]     pop_idx, pop_idx_next;
  logic [1:0]     n;
  tok_t [2:0]     tok;
  logic           used, eot, fire, is_alpha, is_digit, punct_hit, op_hit;
  logic [3:0]     punct_idx, op_idx, p;
  logic [15:0]    hits_run;
  logic [KIND_W-1:0] id_kind;

  function automatic logic [OW-1:0] inc_off(input logic [OW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [CW-1:0] inc_col(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] k, input logic [ERR_W-1:0] e,
                                  input logic [OW-1:0] st, input logic [OW-1:0] ln,
                                  input logic [OW-1:0] lc, input logic [CW-1:0] cl);
    tok_t t;
    t.kind  = k;
    t.err   = e;
    t.start = FIELD_W'(st);
    t.len   = FIELD_W'(ln);
    t.line  = FIELD_W'(lc);
    t.col   = COL_W'(cl);
    return t;
  endfunction

  assign fire     = in_valid && in_ready;
  assign in_ready = !qs.full;
  assign eot      = end_of_text || (text_byte == CH_NUL);
  assign is_digit = (text_byte >= "0") && (text_byte <= "9");
  assign is_alpha = ((text_byte >= "a") && (text_byte <= "z")) ||
                    ((text_byte >= "A") && (text_byte <= "Z")) || (text_byte == "_");
  assign hits_run = (llen < OW'(8)) ? kw_hits(llen[2:0], text_byte) : '0;

  always_comb begin
    punct_hit = 1'b0;
    punct_idx = '0;
    op_hit    = 1'b0;
    op_idx    = '0;
    for (int i = 0; i < 9; i++) begin
      if (text_byte == PUNCT_CH[i]) begin
        punct_hit = 1'b1;
        punct_idx = 4'(i);
      end
    end
    for (int i = 0; i < 10; i++) begin
      if (text_byte == OP_FIRST[i]) begin
        op_hit = 1'b1;
        op_idx = 4'(i);
      end
    end
  end

  // lowest keyword whose text still matches and whose length is reached
  always_comb begin
    id_kind = K_IDENT;
    for (int k = 15; k >= 0; k--) begin
      if (kw[k] && (llen == OW'(KW_LEN[k]))) id_kind = K_KW0 + KIND_W'(k);
    end
  end

  always_comb begin
    mode_next     = mode;
    pos_next      = pos;
    tstart_next   = tstart;
    line_next     = line;
    col_next      = col;
    tcol_next     = tcol;
    kw_next       = kw;
    esc_next      = esc;
    held_dot_next = held_dot;
    pop_idx_next  = pop_idx;
    dot_off_next  = dot_off;
    dot_col_next  = dot_col;
    llen_next     = llen;
    n             = '0;
    tok           = '0;
    used          = 1'b0;
    p             = (pop_idx < 4'd10) ? pop_idx : 4'd0;

    case (mode)
      M_ENDED: begin
        tok[n] = mk_tok(K_END, ERR_NONE, pos_next, '0, line_next, col_next);
        n = n + 2'd1;
        used = 1'b1;
      end
      M_COMMENT: begin
        if (eot || text_byte == CH_LF) begin
          mode_next = M_IDLE;
        end else begin
          pos_next = inc_off(pos_next);
          col_next = inc_col(col_next);
          used = 1'b1;
        end
      end
      M_IDENT: begin
        if (!eot && (is_alpha || is_digit)) begin
          kw_next   = kw_next & hits_run;
          pos_next  = inc_off(pos_next);
          col_next  = inc_col(col_next);
          llen_next = inc_off(llen_next);
          used = 1'b1;
        end else begin
          tok[n] = mk_tok(id_kind, ERR_NONE, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (!eot && is_digit) begin
          pos_next  = inc_off(pos_next);
          col_next  = inc_col(col_next);
          llen_next = inc_off(llen_next);
          used = 1'b1;
        end else if (!eot && text_byte == CH_DOT) begin
          dot_off_next  = pos_next;
          dot_col_next  = col_next;
          pos_next      = inc_off(pos_next);
          col_next      = inc_col(col_next);
          held_dot_next = 1'b1;
          mode_next     = M_NUMDOT;
          used = 1'b1;
        end else begin
          tok[n] = mk_tok(K_INT, ERR_NONE, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_NUMDOT: begin
        held_dot_next = 1'b0;
        if (!eot && is_digit) begin
          // dot joins the lexeme, then the digit
          llen_next = inc_off(inc_off(llen_next));
          pos_next  = inc_off(pos_next);
          col_next  = inc_col(col_next);
          mode_next = M_FLOAT;
          used = 1'b1;
        end else begin
          tok[n] = mk_tok(K_INT, ERR_NONE, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
          tok[n] = mk_tok(K_DOT, ERR_NONE, dot_off_next, OW'(1), line_next, dot_col_next);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_FLOAT: begin
        if (!eot && is_digit) begin
          pos_next  = inc_off(pos_next);
          col_next  = inc_col(col_next);
          llen_next = inc_off(llen_next);
          used = 1'b1;
        end else begin
          tok[n] = mk_tok(K_FLOAT, ERR_NONE, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
          mode_next = M_IDLE;
        end
      end
      M_STRING: begin
        used = 1'b1;
        if (eot) begin
          tok[n] = mk_tok(K_ERROR, ERR_STRING, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
          esc_next  = 1'b0;
          mode_next = M_IDLE;
          used = 1'b0;
        end else begin
          pos_next  = inc_off(pos_next);
          col_next  = inc_col(col_next);
          llen_next = inc_off(llen_next);
          if (esc) begin
            esc_next = 1'b0;
          end else if (text_byte == CH_BSL) begin
            esc_next = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            tok[n] = mk_tok(K_STRING, ERR_NONE, tstart_next, llen_next, line_next, tcol_next);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (text_byte == CH_LF) begin
            line_next = inc_off(line_next);
            col_next  = CW'(1);
          end
        end
      end
      M_OP: begin
        mode_next = M_IDLE;
        if (!eot && text_byte == OP_SECOND[p]) begin
          pos_next  = inc_off(pos_next);
          col_next  = inc_col(col_next);
          llen_next = inc_off(llen_next);
          tok[n] = mk_tok(OP_DOUBLE[p], ERR_NONE, tstart_next, llen_next, line_next,
                          tcol_next);
          n = n + 2'd1;
          used = 1'b1;
        end else begin
          tok[n] = mk_tok(OP_SINGLE[p], OP_ERR[p], tstart_next, llen_next, line_next,
                          tcol_next);
          n = n + 2'd1;
        end
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    if (!used) begin
      if (eot) begin
        tstart_next = pos_next;
        tcol_next   = col_next;
        llen_next   = '0;
        tok[n] = mk_tok(K_END, ERR_NONE, tstart_next, '0, line_next, tcol_next);
        n = n + 2'd1;
        mode_next = M_ENDED;
      end else if (text_byte == CH_SPACE || text_byte == CH_CR || text_byte == CH_TAB) begin
        pos_next = inc_off(pos_next);
        col_next = inc_col(col_next);
      end else if (text_byte == CH_HASH) begin
        pos_next  = inc_off(pos_next);
        col_next  = inc_col(col_next);
        mode_next = M_COMMENT;
      end else begin
        tstart_next = pos_next;
        tcol_next   = col_next;
        pos_next    = inc_off(pos_next);
        col_next    = inc_col(col_next);
        llen_next   = OW'(1);
        if (is_alpha) begin
          kw_next   = kw_hits(3'd0, text_byte);
          mode_next = M_IDENT;
        end else if (is_digit) begin
          mode_next = M_NUMBER;
        end else if (punct_hit) begin
          tok[n] = mk_tok(KIND_W'(punct_idx), ERR_NONE, tstart_next, llen_next, line_next,
                          tcol_next);
          n = n + 2'd1;
        end else if (op_hit) begin
          pop_idx_next = op_idx;
          mode_next    = M_OP;
        end else if (text_byte == CH_QUOTE) begin
          esc_next  = 1'b0;
          mode_next = M_STRING;
        end else if (text_byte == CH_LF) begin
          line_next = inc_off(line_next);
          col_next  = CW'(1);
          tok[n] = mk_tok(K_NEWLINE, ERR_NONE, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
        end else begin
          tok[n] = mk_tok(K_ERROR, ERR_BYTE, tstart_next, llen_next, line_next, tcol_next);
          n = n + 2'd1;
        end
      end
    end

    bundle.cnt = n;
    bundle.tok = tok;
    push       = fire && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      pos      <= '0;
      tstart   <= '0;
      line     <= OW'(1);
      col      <= CW'(1);
      tcol     <= CW'(1);
      kw       <= '1;
      esc      <= 1'b0;
      held_dot <= 1'b0;
      pop_idx  <= '0;
      dot_off  <= '0;
      dot_col  <= '0;
      llen     <= '0;
    end else if (fire) begin
      mode     <= mode_next;
      pos      <= pos_next;
      tstart   <= tstart_next;
      line     <= line_next;
      col      <= col_next;
      tcol     <= tcol_next;
      kw       <= kw_next;
      esc      <= esc_next;
      held_dot <= held_dot_next;
      pop_idx  <= pop_idx_next;
      dot_off  <= dot_off_next;
      dot_col  <= dot_col_next;
      llen     <= llen_next;
    end
  end

`ifndef SYNTHESIS
  a_dot_mode: assert property (@(posedge clk) disable iff (rst)
    held_dot == (mode == M_NUMDOT))
    else $error("held dot out of step with scan mode");
  a_esc_string: assert property (@(posedge clk) disable iff (rst)
    esc |-> (mode == M_STRING))
    else $error("escape pending outside a string");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    (line != '0) && (col != '0))
    else $error("line or column dropped to zero");
  a_ended_stays: assert property (@(posedge clk) disable iff (rst)
    (mode == M_ENDED) |=> (mode == M_ENDED))
    else $error("scanner left the ended state");
`endif

endmodule

[src/source_text_tokenizer_unit.sv]
// Text tokenizer: one source byte per cycle in while the bundle queue has room,
// one token word per cycle out while m_tready is high. A closed token is written
// into the 4-entry bundle queue, then loaded into the back end's bundle register.
// A byte closing 2 or 3 tokens sends them out one by one; the queue absorbs this.
// Reset (rst, synchronous): scanner idle at offset 0, line 1, column 1; queue empty.
module source_text_tokenizer_unit import stt_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] text_byte
  input  logic [0:0]   s_tuser,   // [0] end_of_text
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // error_code, start_offset, token_length,
                                  // line_number, column_number, zero pad
  output logic [5:0]   m_tuser,   // [5:0] token_kind
  output logic         m_tlast
);

  qwr_t    qs;
  logic    q_push, q_full;
  bundle_t push_data, q_data;
  logic    q_avail, q_pop;
  tok_t    tok;

  assign qs = '{push: q_push, full: q_full};

  stt_front #(.OFFSET_BITS(OFFSET_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .text_byte   (s_tdata),
    .end_of_text (s_tuser[0]),
    .qs          (qs),
    .push        (q_push),
    .bundle      (push_data)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_data)
  );

  stt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (tok),
    .out_last  (m_tlast)
  );

  assign m_tuser = tok.kind;
  assign m_tdata = {5'b0, tok.col, tok.line, tok.len, tok.start, tok.err};

endmodule
